// ===== design/ttps_pkg.sv =====
// ttps_pkg: shared types, constants and codes of the transposition table store
// no dependencies
package ttps_pkg;

   localparam int TABLE_SLOTS    = 4096;
   localparam int PROBE_DISTANCE = 4;
   localparam int MATE_LIMIT     = 30000;
   localparam int IDX_W          = $clog2(TABLE_SLOTS);
   localparam int SIZE_W         = 13;
   localparam int PROBE_W        = $clog2(PROBE_DISTANCE + 2);
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [0:0] FUNC_LOOKUP = 1'b0;
   localparam logic [0:0] FUNC_STORE  = 1'b1;

   localparam logic [2:0] ST_MISS    = 3'd0;
   localparam logic [2:0] ST_SOFT    = 3'd1;
   localparam logic [2:0] ST_HARD    = 3'd2;
   localparam logic [2:0] ST_STORED  = 3'd3;
   localparam logic [2:0] ST_REFUSED = 3'd4;

   localparam logic [1:0] KIND_EXACT = 2'd0;
   localparam logic [1:0] KIND_UPPER = 2'd1;
   localparam logic [1:0] KIND_LOWER = 2'd2;

   localparam logic [0:0] CSR_ENABLE = 1'b0;
   localparam logic [0:0] CSR_SLOTS  = 1'b1;

   typedef struct packed {
      logic [0:0]         func;
      logic [31:0]        hash_key;
      logic [63:0]        signature;
      logic [7:0]         search_depth;
      logic signed [15:0] alpha_bound;
      logic signed [15:0] beta_bound;
      logic signed [15:0] entry_value;
      logic [7:0]         entry_depth;
      logic [1:0]         bound_kind;
      logic [15:0]        best_move;
      logic [0:0]         root_of_pv;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [15:0] found_value;
      logic [7:0]         found_depth;
      logic [1:0]         found_kind;
      logic [15:0]        found_move;
      logic [0:0]         replaced_other;
      logic [31:0]        replacement_count;
   } rsp_type;

   // classified job handed from front to back
   typedef struct packed {
      req_type           req;
      logic              active;  // table must be searched
      logic [IDX_W-1:0]  home;
      logic [SIZE_W-1:0] size;
   } job_type;

endpackage

// ===== design/ttps_front.sv =====
// ttps_front: accepts requests, computes home slot (hash mod size) serially
// depends on ttps_pkg
module ttps_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ttps_pkg::req_type  req_data,
   input  logic               cfg_enable,
   input  logic [12:0]        cfg_slots,
   output logic               job_valid,
   input  logic               job_ready,
   output ttps_pkg::job_type  job_data
);
   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV  = 3'b010,
      F_OUT  = 3'b100
   } fstate_type;

   fstate_type state_ff, state_in;
   ttps_pkg::req_type req_ff, req_in;
   logic [ttps_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [ttps_pkg::SIZE_W:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [5:0] cnt_ff, cnt_in;
   logic active_ff, active_in;
   logic [ttps_pkg::SIZE_W-1:0] lsize;
   logic [ttps_pkg::SIZE_W:0] trial;

   always_comb begin
      if (cfg_slots == '0) lsize = ttps_pkg::SIZE_W'(1);
      else if ({19'd0, cfg_slots} > ttps_pkg::TABLE_SLOTS)
         lsize = ttps_pkg::SIZE_W'(ttps_pkg::TABLE_SLOTS);
      else lsize = cfg_slots;
   end

   assign req_ready = state_ff == F_IDLE;
   assign trial = {rem_ff[ttps_pkg::SIZE_W-1:0], quo_ff[31]};

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      size_in   = size_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               size_in   = lsize;
               rem_in    = '0;
               quo_in    = req_data.hash_key;
               cnt_in    = 6'd0;
               active_in = cfg_enable && req_data.signature != 64'd0 &&
                  (req_data.func == ttps_pkg::FUNC_LOOKUP ||
                   (int'(req_data.entry_value) > -ttps_pkg::MATE_LIMIT &&
                    int'(req_data.entry_value) < ttps_pkg::MATE_LIMIT));
               state_in  = F_DIV;
            end
         end
         F_DIV: begin
            // restoring division, one bit per cycle
            if (trial >= {1'b0, size_ff}) rem_in = trial - {1'b0, size_ff};
            else rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) state_in = F_OUT;
         end
         F_OUT: if (job_ready) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= F_IDLE;
      else state_ff <= state_in;
      req_ff    <= req_in;
      size_ff   <= size_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      active_ff <= active_in;
   end

   assign job_valid       = state_ff == F_OUT;
   assign job_data.req    = req_ff;
   assign job_data.active = active_ff;
   assign job_data.home   = rem_ff[ttps_pkg::IDX_W-1:0];
   assign job_data.size   = size_ff;
endmodule

// ===== design/ttps_queue.sv =====
// ttps_queue: two-entry job queue between front and back
// depends on ttps_pkg
module ttps_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ttps_pkg::job_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output ttps_pkg::job_type out_data
);
   ttps_pkg::job_type mem_ff [ttps_pkg::QUEUE_DEPTH];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule

// ===== design/ttps_back.sv =====
// ttps_back: probes the slot memories, decides the result, writes the slot
// depends on ttps_pkg
module ttps_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  ttps_pkg::job_type job_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ttps_pkg::rsp_type rsp_data,
   output logic              busy
);
   localparam int IW = ttps_pkg::IDX_W;
   localparam int SLOTS = ttps_pkg::TABLE_SLOTS;

   typedef enum logic [5:0] {
      B_CLEAR = 6'b000001,
      B_IDLE  = 6'b000010,
      B_READ  = 6'b000100,
      B_CHECK = 6'b001000,
      B_FETCH = 6'b010000,
      B_DONE  = 6'b100000
   } bstate_type;

   logic [63:0] sig_mem [SLOTS];
   logic [41:0] pay_mem [SLOTS];
   logic        root_mem [SLOTS];

   bstate_type state_ff, state_in;
   ttps_pkg::job_type job_ff;
   logic [IW-1:0] idx_ff, idx_in, clr_ff;
   logic [ttps_pkg::PROBE_W-1:0] step_ff, step_in;
   logic [63:0] rsig_ff;
   logic [41:0] rpay_ff;
   logic rroot_ff;
   logic [31:0] count_ff, count_in;
   ttps_pkg::rsp_type out_ff, out_in;
   logic out_valid_ff, out_valid_in;
   logic we;
   logic [IW-1:0] waddr, nidx;
   logic [63:0] wsig;
   logic [41:0] wpay;
   logic wroot;
   logic is_store, match, last;
   logic signed [15:0] pval;
   logic [7:0] pdepth;
   logic [1:0] pkind;

   always_comb begin
      if ({1'b0, idx_ff} + 1'b1 >= (IW+1)'(job_ff.size)) nidx = '0;
      else nidx = idx_ff + 1'b1;
   end

   assign is_store = job_ff.req.func == ttps_pkg::FUNC_STORE;
   assign match = rsig_ff == job_ff.req.signature || (is_store && rsig_ff == 64'd0);
   assign last = step_ff == ttps_pkg::PROBE_W'(ttps_pkg::PROBE_DISTANCE);
   assign pval = rpay_ff[15:0];
   assign pdepth = rpay_ff[23:16];
   assign pkind = rpay_ff[25:24];
   assign job_ready = state_ff == B_IDLE && !out_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;
   assign busy = state_ff != B_IDLE || out_valid_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      step_in = step_ff;
      count_in = count_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      we = 1'b0;
      waddr = clr_ff;
      wsig = 64'd0;
      wpay = {job_ff.req.best_move, job_ff.req.bound_kind,
              job_ff.req.entry_depth, job_ff.req.entry_value};
      wroot = 1'b0;
      case (state_ff)
         B_CLEAR: begin
            we = 1'b1;
            if (clr_ff == IW'(SLOTS - 1)) state_in = B_IDLE;
         end
         B_IDLE: begin
            if (job_valid && job_ready) begin
               idx_in = job_data.home;
               step_in = '0;
               if (job_data.active) state_in = B_READ;
               else begin
                  out_in = '0;
                  out_in.status = job_data.req.func == ttps_pkg::FUNC_STORE ?
                     ttps_pkg::ST_REFUSED : ttps_pkg::ST_MISS;
                  out_in.replacement_count = count_ff;
                  out_valid_in = 1'b1;
               end
            end
         end
         B_READ: state_in = B_CHECK;
         B_CHECK: begin
            if (match) begin
               state_in = B_FETCH;
            end else if (last) begin
               if (is_store) begin
                  idx_in = job_ff.home;
                  state_in = B_FETCH;
               end else begin
                  out_in = '0;
                  out_in.status = ttps_pkg::ST_MISS;
                  out_in.replacement_count = count_ff;
                  state_in = B_DONE;
               end
            end else begin
               idx_in = nidx;
               step_in = step_ff + 1'b1;
               state_in = B_READ;
            end
         end
         B_FETCH: state_in = B_DONE;  // registered read of chosen slot
         B_DONE: begin
            if (out_valid_in) begin
               state_in = B_DONE;
            end else begin
               state_in = B_IDLE;
               out_valid_in = 1'b1;
               if (is_store) begin
                  out_in = '0;
                  if (!job_ff.req.root_of_pv[0] && rroot_ff) begin
                     out_in.status = ttps_pkg::ST_REFUSED;
                     out_in.replacement_count = count_ff;
                  end else begin
                     we = 1'b1;
                     waddr = idx_ff;
                     wsig = job_ff.req.signature;
                     wroot = job_ff.req.root_of_pv[0];
                     out_in.status = ttps_pkg::ST_STORED;
                     if (rsig_ff != 64'd0 && rsig_ff != job_ff.req.signature) begin
                        count_in = count_ff + 32'd1;
                        out_in.replaced_other = 1'b1;
                     end
                     out_in.replacement_count = count_in;
                  end
               end else if (out_ff.status != ttps_pkg::ST_MISS || match) begin
                  out_in = '0;
                  out_in.replacement_count = count_ff;
                  out_in.found_value = pval;
                  out_in.found_depth = pdepth;
                  out_in.found_kind = pkind;
                  out_in.found_move = rpay_ff[41:26];
                  out_in.status = ttps_pkg::ST_SOFT;
                  if (pdepth >= job_ff.req.search_depth) begin
                     if (pkind == ttps_pkg::KIND_EXACT) out_in.status = ttps_pkg::ST_HARD;
                     else if (pkind == ttps_pkg::KIND_UPPER && pval < job_ff.req.alpha_bound)
                     begin
                        out_in.found_value = job_ff.req.alpha_bound;
                        out_in.status = ttps_pkg::ST_HARD;
                     end else if (pkind == ttps_pkg::KIND_LOWER &&
                                  pval > job_ff.req.beta_bound) begin
                        out_in.found_value = job_ff.req.beta_bound;
                        out_in.status = ttps_pkg::ST_HARD;
                     end
                  end
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff <= '0;
         count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_CLEAR) clr_ff <= clr_ff + 1'b1;
         count_ff <= count_in;
         out_valid_ff <= out_valid_in;
      end
      if (state_ff == B_IDLE && job_valid && job_ready) job_ff <= job_data;
      idx_ff <= idx_in;
      step_ff <= step_in;
      out_ff <= out_in;
      if (we) begin
         sig_mem[waddr] <= wsig;
         root_mem[waddr] <= wroot;
         if (state_ff != B_CLEAR) pay_mem[waddr] <= wpay;
      end
      if (state_ff != B_DONE || out_valid_in) begin
         rsig_ff <= sig_mem[idx_in];
         rroot_ff <= root_mem[idx_in];
         rpay_ff <= pay_mem[idx_in];
      end
   end
endmodule

// ===== design/transposition_table_probe_store.sv =====
// transposition_table_probe_store: top level, csr block plus front, queue, back
// depends on ttps_pkg, ttps_front, ttps_queue, ttps_back
//
//   channel  direction  handshake              payload
//   req_     in         req_valid/req_ready    req_data (ttps_pkg::req_type)
//   rsp_     out        rsp_valid/rsp_ready    rsp_data (ttps_pkg::rsp_type)
//   csr_     in         csr_valid/csr_ready    csr_index, csr_wdata
//
// front: a bit-serial hash mod size divider, taking one request at a time
// back: read and check states per probed slot, then fetch (not on a lookup miss) and done
// after reset the back clears 4096 signature slots, one per cycle, before any request
// a held result stalls the back; the two-entry queue keeps the front dividing until it fills
module transposition_table_probe_store (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ttps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ttps_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [0:0]        csr_index,
   input  logic [12:0]       csr_wdata
);
   logic enable_ff;
   logic [12:0] slots_ff;
   logic fj_valid, fj_ready, bj_valid, bj_ready, back_busy;
   ttps_pkg::job_type fj_data, bj_data;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         slots_ff <= 13'd4096;
      end else if (csr_valid) begin
         case (csr_index)
            ttps_pkg::CSR_ENABLE: enable_ff <= csr_wdata[0];
            ttps_pkg::CSR_SLOTS:  slots_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ttps_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .cfg_enable(enable_ff), .cfg_slots(slots_ff),
      .job_valid(fj_valid), .job_ready(fj_ready), .job_data(fj_data));

   ttps_queue u_queue (
      .clock, .reset, .in_valid(fj_valid), .in_ready(fj_ready), .in_data(fj_data),
      .out_valid(bj_valid), .out_ready(bj_ready), .out_data(bj_data));

   ttps_back u_back (
      .clock, .reset, .job_valid(bj_valid), .job_ready(bj_ready), .job_data(bj_data),
      .rsp_valid, .rsp_ready, .rsp_data, .busy(back_busy));

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.status != ttps_pkg::ST_STORED
      |-> !rsp_data.replaced_other) else $error("replace flag on non-store");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ttps_pkg::ST_MISS
      |-> rsp_data.found_move == 16'd0 && rsp_data.found_depth == 8'd0)
      else $error("miss carries data");
   a_job_busy: assert property (@(posedge clock) disable iff (reset)
      bj_valid && bj_ready |=> back_busy) else $error("back idle after job");
endmodule

// ===== bench/transposition_table_probe_store_tb.sv =====
// transposition_table_probe_store_tb: self-checking bench for the probing table store
// depends on ttps_pkg and transposition_table_probe_store
`timescale 1ns / 1ps

module transposition_table_probe_store_tb;

   localparam int IDLE_PCT  = 22;
   localparam int WD_LIMIT  = 30000;
   localparam int HOLD_LONG = 600;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ttps_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ttps_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [0:0]        csr_index = ttps_pkg::CSR_ENABLE;
   logic [12:0]       csr_wdata = '0;

   // mirror of the table contents
   logic [63:0]        tab_sig [ttps_pkg::TABLE_SLOTS];
   logic signed [15:0] tab_val [ttps_pkg::TABLE_SLOTS];
   logic [7:0]         tab_depth [ttps_pkg::TABLE_SLOTS];
   logic [1:0]         tab_kind [ttps_pkg::TABLE_SLOTS];
   logic [15:0]        tab_move [ttps_pkg::TABLE_SLOTS];
   logic               tab_root [ttps_pkg::TABLE_SLOTS];
   logic [31:0]        overwrite_total;
   logic               tab_on;
   logic [12:0]        tab_slots;

   ttps_pkg::rsp_type pending_rsp[$];
   logic [63:0] sig_pool [12];
   logic [31:0] hash_pool [12];
   int          errors = 0;
   int          wd_count = 0;
   int          hold_req = 0;
   int          hold_left = 0;
   bit          steady = 0;

   transposition_table_probe_store dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic ttps_pkg::rsp_type lookup_or_store(ttps_pkg::req_type r);
      ttps_pkg::rsp_type e;
      int unsigned       n, home, idx, i;
      bit                ok;
      e = '0;
      n = (tab_slots == 0) ? 1 :
          ((tab_slots > ttps_pkg::TABLE_SLOTS) ? ttps_pkg::TABLE_SLOTS : tab_slots);
      home = r.hash_key % n;
      idx = home;
      ok = 0;
      if (r.func == ttps_pkg::FUNC_LOOKUP) begin
         e.status = ttps_pkg::ST_MISS;
         if (tab_on && r.signature != 0) begin
            for (i = 0; i <= ttps_pkg::PROBE_DISTANCE && !ok; i++) begin
               if (i != 0) idx = (idx + 1) % n;
               if (tab_sig[idx] == r.signature) ok = 1;
            end
            if (ok) begin
               e.status = ttps_pkg::ST_SOFT;
               e.found_value = tab_val[idx];
               e.found_depth = tab_depth[idx];
               e.found_kind = tab_kind[idx];
               e.found_move = tab_move[idx];
               if (tab_depth[idx] >= r.search_depth) begin
                  if (tab_kind[idx] == ttps_pkg::KIND_EXACT) begin
                     e.status = ttps_pkg::ST_HARD;
                  end else if (tab_kind[idx] == ttps_pkg::KIND_UPPER &&
                               tab_val[idx] < r.alpha_bound) begin
                     e.status = ttps_pkg::ST_HARD;
                     e.found_value = r.alpha_bound;
                  end else if (tab_kind[idx] == ttps_pkg::KIND_LOWER &&
                               tab_val[idx] > r.beta_bound) begin
                     e.status = ttps_pkg::ST_HARD;
                     e.found_value = r.beta_bound;
                  end
               end
            end
         end
      end else begin
         e.status = ttps_pkg::ST_REFUSED;
         if (r.entry_value > -ttps_pkg::MATE_LIMIT && r.entry_value < ttps_pkg::MATE_LIMIT
             && tab_on && r.signature != 0) begin
            for (i = 0; i <= ttps_pkg::PROBE_DISTANCE && !ok; i++) begin
               if (i != 0) idx = (idx + 1) % n;
               if (tab_sig[idx] == 0 || tab_sig[idx] == r.signature) ok = 1;
            end
            if (!ok) idx = home;
            // a root-marked slot only takes another root entry
            if (!(r.root_of_pv == 1'b0 && tab_root[idx])) begin
               if (tab_sig[idx] != 0 && tab_sig[idx] != r.signature) begin
                  overwrite_total = overwrite_total + 1;
                  e.replaced_other = 1'b1;
               end
               tab_sig[idx] = r.signature;
               tab_val[idx] = r.entry_value;
               tab_depth[idx] = r.entry_depth;
               tab_kind[idx] = r.bound_kind;
               tab_move[idx] = r.best_move;
               tab_root[idx] = r.root_of_pv;
               e.status = ttps_pkg::ST_STORED;
            end
         end
      end
      e.replacement_count = overwrite_total;
      return e;
   endfunction

   task automatic send_item(ttps_pkg::req_type it);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(lookup_or_store(it));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [12:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == ttps_pkg::CSR_ENABLE) tab_on = val[0];
      else tab_slots = val;
      @(posedge clock);
   endtask

   function automatic ttps_pkg::req_type make_item(logic [0:0] f, logic [31:0] h,
                                                   logic [63:0] s);
      ttps_pkg::req_type r;
      r = '0;
      r.func = f;
      r.hash_key = h;
      r.signature = s;
      return r;
   endfunction

   task automatic fill_pools;
      for (int i = 0; i < 12; i++) begin
         sig_pool[i] = {$urandom, $urandom};
         hash_pool[i] = $urandom;
      end
   endtask

   function automatic ttps_pkg::req_type random_item;
      ttps_pkg::req_type r;
      int                k;
      k = int'($urandom_range(11));
      r.func = 1'($urandom_range(1));
      r.hash_key = ($urandom_range(9) < 8) ? hash_pool[k] : $urandom;
      case ($urandom_range(19))
         0:       r.signature = '0;
         1, 2:    r.signature = {$urandom, $urandom};
         default: r.signature = sig_pool[k];
      endcase
      r.search_depth = 8'($urandom);
      r.alpha_bound = 16'($urandom);
      r.beta_bound = 16'($urandom);
      r.entry_value = ($urandom_range(7) == 0) ?
                      16'((ttps_pkg::MATE_LIMIT - 2 + int'($urandom_range(3))) *
                          (($urandom_range(1) != 0) ? 1 : -1)) :
                      16'($urandom);
      r.entry_depth = 8'($urandom);
      r.bound_kind = 2'($urandom);
      r.best_move = 16'($urandom);
      r.root_of_pv = ($urandom_range(5) == 0);
      return r;
   endfunction

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) send_item(random_item());
   endtask

   task automatic test_directed;
      ttps_pkg::req_type r;
      logic [63:0] sa, sb;
      sa = 64'hFFFF_FFFF_FFFF_FFFF;
      sb = 64'h8000_0000_0000_0001;
      // exact entry, then hard and soft hits on depth
      r = make_item(ttps_pkg::FUNC_STORE, 32'hFFFF_FFFF, sa);
      r.entry_value = 100; r.entry_depth = 10; r.bound_kind = ttps_pkg::KIND_EXACT;
      r.best_move = 16'hFFFF;
      send_item(r);
      r = make_item(ttps_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, sa); r.search_depth = 10;
      send_item(r);
      r.search_depth = 11; send_item(r);
      r.search_depth = 8'hFF; send_item(r);
      // upper bound clamps to alpha
      r = make_item(ttps_pkg::FUNC_STORE, 32'h0, sb);
      r.entry_value = -50; r.entry_depth = 8'hFF; r.bound_kind = ttps_pkg::KIND_UPPER;
      send_item(r);
      r = make_item(ttps_pkg::FUNC_LOOKUP, 32'h0, sb); r.alpha_bound = -10; send_item(r);
      r.alpha_bound = -60; send_item(r);
      r.alpha_bound = 16'sh7FFF; send_item(r);
      // lower bound clamps to beta
      r = make_item(ttps_pkg::FUNC_STORE, 32'h0, sb);
      r.entry_value = 50; r.entry_depth = 3; r.bound_kind = ttps_pkg::KIND_LOWER;
      send_item(r);
      r = make_item(ttps_pkg::FUNC_LOOKUP, 32'h0, sb); r.beta_bound = 10; send_item(r);
      r.beta_bound = -16'sh8000; send_item(r);
      r.beta_bound = 60; send_item(r);
      // bound kind three only gives soft hits
      r = make_item(ttps_pkg::FUNC_STORE, 32'h0, sb); r.bound_kind = 2'd3; send_item(r);
      r = make_item(ttps_pkg::FUNC_LOOKUP, 32'h0, sb); send_item(r);
      // mate guard on both sides
      r = make_item(ttps_pkg::FUNC_STORE, 32'h5, 64'h1234);
      r.entry_value = 30000; send_item(r);
      r.entry_value = -30000; send_item(r);
      r.entry_value = 16'sh7FFF; send_item(r);
      r.entry_value = -16'sh8000; send_item(r);
      r.entry_value = 29999; send_item(r);
      // zero signature
      r = make_item(ttps_pkg::FUNC_LOOKUP, 32'h5, 64'h0); send_item(r);
      r.func = ttps_pkg::FUNC_STORE; send_item(r);
      // root protection
      r = make_item(ttps_pkg::FUNC_STORE, 32'h7, 64'h77); r.root_of_pv = 1'b1; send_item(r);
      r.signature = 64'h78; r.root_of_pv = 1'b0; send_item(r);
      r.root_of_pv = 1'b1; send_item(r);
      drain();
   endtask

   task automatic test_disabled;
      write_csr(ttps_pkg::CSR_ENABLE, 13'd0);
      run_random(60);
      drain();
      write_csr(ttps_pkg::CSR_ENABLE, 13'd1);
   endtask

   task automatic test_sizes;
      logic [12:0] sizes [8] = '{13'd1, 13'd0, 13'd5, 13'd8191, 13'd2, 13'd13,
                                 13'd4095, 13'd4096};
      foreach (sizes[i]) begin
         fill_pools();
         write_csr(ttps_pkg::CSR_SLOTS, sizes[i]);
         run_random(200);
         drain();
      end
   endtask

   task automatic test_steady_stream;
      fill_pools();
      write_csr(ttps_pkg::CSR_SLOTS, 13'd7);
      steady = 1;
      run_random(150);
      drain();
      steady = 0;
   endtask

   task automatic test_backpressure;
      write_csr(ttps_pkg::CSR_SLOTS, 13'd9);
      hold_req = HOLD_LONG;
      run_random(40);
      drain();
   endtask

   task automatic test_pause_until_empty;
      write_csr(ttps_pkg::CSR_SLOTS, 13'd3);
      run_random(20);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
      run_random(20);
      drain();
   endtask

   // receiver side
   always @(posedge clock) begin
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic field_diff(string name, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
   endtask

   always @(posedge clock) begin
      ttps_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected result transfer, expected none, got %0h",
                     $time, rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status)
               field_diff("status", want.status, rsp_data.status);
            if (rsp_data.found_value !== want.found_value)
               field_diff("found_value", want.found_value, rsp_data.found_value);
            if (rsp_data.found_depth !== want.found_depth)
               field_diff("found_depth", want.found_depth, rsp_data.found_depth);
            if (rsp_data.found_kind !== want.found_kind)
               field_diff("found_kind", want.found_kind, rsp_data.found_kind);
            if (rsp_data.found_move !== want.found_move)
               field_diff("found_move", want.found_move, rsp_data.found_move);
            if (rsp_data.replaced_other !== want.replaced_other)
               field_diff("replaced_other", want.replaced_other, rsp_data.replaced_other);
            if (rsp_data.replacement_count !== want.replacement_count)
               field_diff("replacement_count", want.replacement_count,
                          rsp_data.replacement_count);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         wd_count <= 0;
      else
         wd_count <= wd_count + 1;
      if (wd_count >= WD_LIMIT) begin
         $display("transposition_table_probe_store_tb NOT OK");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < ttps_pkg::TABLE_SLOTS; i++) begin
         tab_sig[i] = '0;
         tab_root[i] = 1'b0;
      end
      overwrite_total = '0;
      tab_on = 1'b1;
      tab_slots = 13'd4096;
      fill_pools();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_csr(ttps_pkg::CSR_ENABLE, 13'd1);
      write_csr(ttps_pkg::CSR_SLOTS, 13'd4096);
      test_directed();
      test_disabled();
      test_sizes();
      test_steady_stream();
      test_backpressure();
      test_pause_until_empty();
      if (errors == 0)
         $display("transposition_table_probe_store_tb OK");
      else
         $display("transposition_table_probe_store_tb NOT OK");
      $finish;
   end

endmodule
